### hw/rtl/isid_pkg.sv
// shared types and constants for the imu stationary init detector
// no dependencies; used by isid_iter and imu_stationary_init_detector
`default_nettype none
package isid_pkg;

  localparam int unsigned ARG_W = 64;
  localparam int unsigned DVS_W = 32;

  localparam logic [19:0] G_Q16        = 20'd642908;
  localparam logic [31:0] ONE_Q16      = 32'd65536;
  localparam logic [31:0] VAR_INIT_Q16 = 32'd6554;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef enum logic [2:0] {
    ST_COLLECT   = 3'd0,
    ST_ACCEPT    = 3'd1,
    ST_UNSTEADY  = 3'd2,
    ST_REJ_MOVE  = 3'd3,
    ST_REJ_MEAN  = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  localparam logic [2:0] CFG_MIN_ACCEL  = 3'd0;
  localparam logic [2:0] CFG_MAX_ACCEL  = 3'd1;
  localparam logic [2:0] CFG_MAX_GMEAN  = 3'd2;
  localparam logic [2:0] CFG_MAX_ASTD   = 3'd3;
  localparam logic [2:0] CFG_MAX_GSTD   = 3'd4;
  localparam logic [2:0] CFG_MIN_TOTAL  = 3'd5;
  localparam logic [2:0] CFG_MIN_WINDOW = 3'd6;
  localparam logic [2:0] CFG_REPLAY     = 3'd7;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/isid_iter.sv
// shared bit-serial unit: unsigned divide (one quotient bit a cycle)
// and floor square root (one root bit a cycle); uses isid_pkg
`default_nettype none
module isid_iter (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire isid_pkg::iter_req_t     req,
  input  wire logic [63:0]             arg_a,
  input  wire logic [31:0]             arg_b,
  output logic                         done,
  output logic [63:0]                  res
);

  logic                busy_r;
  logic                done_r;
  isid_pkg::iter_op_t  op_r;
  logic [5:0]          cnt_r;
  logic [63:0]         src_r;
  logic [35:0]         rem_r;
  logic [63:0]         res_r;
  logic [31:0]         dvs_r;

  logic [35:0] rsh;
  logic [35:0] trial;
  logic [36:0] diff;
  logic        ge;
  logic [5:0]  last;

  always_comb begin
    unique case (op_r)
      isid_pkg::OP_SQRT: begin
        rsh   = {rem_r[33:0], src_r[63:62]};
        trial = {2'b00, res_r[31:0], 2'b01};
        last  = 6'd31;
      end
      default: begin
        rsh   = {rem_r[34:0], src_r[63]};
        trial = {4'b0000, dvs_r};
        last  = 6'd63;
      end
    endcase
    diff = {1'b0, rsh} - {1'b0, trial};
    ge   = ~diff[36];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= isid_pkg::OP_DIV;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        src_r  <= arg_a;
        rem_r  <= '0;
        res_r  <= '0;
        dvs_r  <= arg_b;
      end else if (busy_r) begin
        rem_r <= ge ? diff[35:0] : rsh;
        res_r <= {res_r[62:0], ge};
        src_r <= (op_r == isid_pkg::OP_SQRT) ? {src_r[61:0], 2'b00} : {src_r[62:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

### hw/rtl/imu_stationary_init_detector.sv
// one sample at a time: in_tready is high only while idle, so a new sample is taken only
// once the result beat of the last one is loaded. the 64-step divide of the shared
// bit-serial unit dominates the work: four divides per axis over six axes. after
// initialization a sample goes straight to a done beat. synchronous active-low reset
// restores state, configuration and statistics. depends on isid_pkg and isid_iter
`default_nettype none
module imu_stationary_init_detector #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, stamp_us
  input  wire logic [239:0]  in_tdata,
  input  wire logic          in_tlast,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // mean_accel_x/y/z, gyro_bias_x/y/z, gravity_x/y/z, sample_total
  output logic [303:0]       out_tdata,
  // status
  output logic [2:0]         out_tuser,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_addr,
  input  wire logic [31:0]   cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_MDIV, S_SQ, S_SQ2, S_PREV, S_PDIV, S_TDIV, S_TM1, S_TM2,
    S_TM3, S_TDIV2, S_NSQ, S_NSQW, S_SA, S_SAW, S_SGW, S_DEC, S_GMUL, S_GMUL2,
    S_GDIV, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0] min_accel_r, max_accel_r, max_gmean_r, max_astd_r, max_gstd_r, min_window_r;
  logic [15:0] min_total_r;
  logic        replay_r;

  // statistics
  logic signed [31:0]    mean_r [6];
  logic [31:0]           var_r [6];
  logic [COUNT_BITS-1:0] cnt_r;
  logic [47:0]           start_r, end_r;
  logic                  started_r, done_r;

  // working registers
  logic signed [31:0] smp_r [6];
  logic               fe_r;
  logic [2:0]         k_r;
  logic [1:0]         j_r;
  logic               base_r;
  logic               neg_r;
  logic [31:0]        ae_r;
  logic [63:0]        tmp_r, acc_r;
  logic [63:0]        mul_p_r;
  logic [31:0]        an_r, gn_r;
  logic [24:0]        asn_r, gsn_r;
  logic signed [31:0] grav_r [3];
  isid_pkg::status_t  st_r;
  logic               gsel_r, rej_r;

  logic [303:0] out_data_r;
  logic [2:0]   out_user_r;
  logic         out_valid_r;

  // shared unit
  isid_pkg::iter_req_t iter_req;
  logic [63:0]         iter_a;
  logic [31:0]         iter_b;
  logic                iter_done;
  logic [63:0]         iter_res;

  isid_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .arg_a (iter_a),
    .arg_b (iter_b),
    .done  (iter_done),
    .res   (iter_res)
  );

  logic [31:0] mul_a, mul_b;

  logic [31:0]        n32, nm1;
  logic signed [32:0] dd, ee;
  logic [31:0]        ad;
  logic signed [33:0] nmean;
  logic [32:0]        qpart;
  logic [63:0]        vtot;
  logic [31:0]        tot32;
  logic [15:0]        tot_sat;
  logic [47:0]        dur;
  logic               enough, still;
  logic [2:0]         nidx;
  logic [33:0]        asum, gsum;
  logic [31:0]        gq;
  logic               in_acc;

  assign in_acc = in_tvalid && in_tready;
  assign n32    = 32'(cnt_r);
  assign nm1    = n32 - 32'd1;
  assign tot32  = nm1;
  assign tot_sat = (tot32 > 32'd65535) ? 16'hFFFF : tot32[15:0];
  assign dur    = (end_r >= start_r) ? (end_r - start_r) : 48'd0;
  assign enough = (tot32 >= {16'd0, min_total_r}) && (dur >= {16'd0, min_window_r});
  assign still  = (an_r <= max_accel_r) && (gn_r <= max_gmean_r) &&
                  ({7'd0, asn_r} <= max_astd_r) && ({7'd0, gsn_r} <= max_gstd_r);
  assign nidx   = base_r ? (3'd3 + {1'b0, j_r}) : {1'b0, j_r};
  assign asum   = {2'b00, var_r[0]} + {2'b00, var_r[1]} + {2'b00, var_r[2]};
  assign gsum   = {2'b00, var_r[3]} + {2'b00, var_r[4]} + {2'b00, var_r[5]};
  assign gq     = iter_res[31:0];

  always_comb begin
    dd    = {smp_r[k_r][31], smp_r[k_r]} - {mean_r[k_r][31], mean_r[k_r]};
    ad    = dd[32] ? 32'(-dd) : dd[31:0];
    qpart = {1'b0, iter_res[31:0]};
    nmean = {{2{mean_r[k_r][31]}}, mean_r[k_r]} +
            (neg_r ? -{1'b0, qpart} : {1'b0, qpart});
    ee    = {smp_r[k_r][31], smp_r[k_r]} - {nmean[31], nmean[31:0]};
    vtot  = acc_r + iter_res;
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        mul_a = ae_r;
        mul_b = ae_r;
      end
      S_SQ2: begin
        mul_a = var_r[k_r];
        mul_b = nm1;
      end
      S_TM1: begin
        mul_a = tmp_r[31:0];
        mul_b = nm1;
      end
      S_TM2: begin
        mul_a = tmp_r[63:32];
        mul_b = nm1;
      end
      S_NSQ: begin
        if (j_r != 2'd3) begin
          mul_a = isid_pkg::mag32(mean_r[nidx]);
          mul_b = isid_pkg::mag32(mean_r[nidx]);
        end
      end
      S_GMUL: begin
        mul_a = isid_pkg::mag32(mean_r[{1'b0, j_r}]);
        mul_b = {12'd0, isid_pkg::G_Q16};
      end
      default: ;
    endcase
  end

  // shared divide / root requests
  always_comb begin
    iter_req.start = 1'b0;
    iter_req.op    = isid_pkg::OP_DIV;
    iter_a         = '0;
    iter_b         = n32;
    unique case (state_r)
      S_DIFF: begin
        iter_req.start = 1'b1;
        iter_a         = {32'd0, ad};
      end
      S_PREV: begin
        iter_req.start = 1'b1;
        iter_a         = mul_p_r;
      end
      S_PDIV: begin
        iter_req.start = iter_done;
        iter_a         = tmp_r;
      end
      S_TM3: begin
        iter_req.start = 1'b1;
        iter_a         = tmp_r + {mul_p_r[31:0], 32'd0};
      end
      S_NSQ: begin
        iter_req.start = (j_r == 2'd3);
        iter_req.op    = isid_pkg::OP_SQRT;
        iter_a         = acc_r + mul_p_r;
      end
      S_SA: begin
        iter_req.start = 1'b1;
        iter_req.op    = isid_pkg::OP_SQRT;
        iter_a         = {14'd0, asum, 16'd0};
      end
      S_SAW: begin
        iter_req.start = iter_done;
        iter_req.op    = isid_pkg::OP_SQRT;
        iter_a         = {14'd0, gsum, 16'd0};
      end
      S_GMUL2: begin
        iter_req.start = 1'b1;
        iter_a         = mul_p_r;
        iter_b         = an_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= {32'd0, mul_a} * {32'd0, mul_b};
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_accel_r  <= 32'd32768;
      max_accel_r  <= 32'd98304;
      max_gmean_r  <= 32'd3277;
      max_astd_r   <= 32'd3277;
      max_gstd_r   <= 32'd1311;
      min_total_r  <= 16'd100;
      min_window_r <= 32'd1000000;
      replay_r     <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        mean_r[i] <= (i == 2) ? -isid_pkg::ONE_Q16 : 32'd0;
        var_r[i]  <= isid_pkg::VAR_INIT_Q16;
      end
      cnt_r       <= COUNT_BITS'(1);
      start_r     <= '0;
      end_r       <= '0;
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          isid_pkg::CFG_MIN_ACCEL:  min_accel_r  <= cfg_wdata;
          isid_pkg::CFG_MAX_ACCEL:  max_accel_r  <= cfg_wdata;
          isid_pkg::CFG_MAX_GMEAN:  max_gmean_r  <= cfg_wdata;
          isid_pkg::CFG_MAX_ASTD:   max_astd_r   <= cfg_wdata;
          isid_pkg::CFG_MAX_GSTD:   max_gstd_r   <= cfg_wdata;
          isid_pkg::CFG_MIN_TOTAL:  min_total_r  <= cfg_wdata[15:0];
          isid_pkg::CFG_MIN_WINDOW: min_window_r <= cfg_wdata;
          isid_pkg::CFG_REPLAY:     replay_r     <= cfg_wdata[0];
          default: ;
        endcase
      end

      // in S_EMIT the beat register is reloaded below instead
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (done_r) begin
              st_r    <= isid_pkg::ST_DONE;
              gsel_r  <= 1'b1;
              rej_r   <= 1'b0;
              state_r <= S_EMIT;
            end else begin
              for (int i = 0; i < 6; i++) begin
                smp_r[i] <= in_tdata[32*i +: 32];
                if (!started_r) mean_r[i] <= in_tdata[32*i +: 32];
              end
              fe_r  <= in_tlast;
              end_r <= in_tdata[239:192];
              if (!started_r) begin
                start_r   <= in_tdata[239:192];
                started_r <= 1'b1;
              end
              k_r     <= '0;
              state_r <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          neg_r   <= dd[32];
          state_r <= S_MDIV;
        end
        S_MDIV: begin
          if (iter_done) begin
            mean_r[k_r] <= nmean[31:0];
            ae_r        <= ee[32] ? 32'(-ee) : ee[31:0];
            state_r     <= S_SQ;
          end
        end
        S_SQ:  state_r <= S_SQ2;
        S_SQ2: begin
          tmp_r   <= {16'd0, mul_p_r[63:16]};
          state_r <= S_PREV;
        end
        S_PREV: state_r <= S_PDIV;
        S_PDIV: begin
          if (iter_done) begin
            acc_r   <= iter_res;
            state_r <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (iter_done) begin
            tmp_r   <= iter_res;
            state_r <= S_TM1;
          end
        end
        S_TM1: state_r <= S_TM2;
        S_TM2: begin
          tmp_r   <= mul_p_r;
          state_r <= S_TM3;
        end
        S_TM3: state_r <= S_TDIV2;
        S_TDIV2: begin
          if (iter_done) begin
            var_r[k_r] <= (vtot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vtot[31:0];
            if (k_r == 3'd5) begin
              if (cnt_r != {COUNT_BITS{1'b1}}) cnt_r <= cnt_r + COUNT_BITS'(1);
              if (fe_r) begin
                j_r     <= '0;
                base_r  <= 1'b0;
                state_r <= S_NSQ;
              end else begin
                st_r    <= isid_pkg::ST_COLLECT;
                gsel_r  <= 1'b0;
                rej_r   <= 1'b0;
                state_r <= S_EMIT;
              end
            end else begin
              k_r     <= k_r + 3'd1;
              state_r <= S_DIFF;
            end
          end
        end
        S_NSQ: begin
          acc_r <= (j_r == 2'd0) ? 64'd0 : acc_r + mul_p_r;
          if (j_r == 2'd3) state_r <= S_NSQW;
          else j_r <= j_r + 2'd1;
        end
        S_NSQW: begin
          if (iter_done) begin
            if (!base_r) begin
              an_r    <= iter_res[31:0];
              base_r  <= 1'b1;
              j_r     <= '0;
              state_r <= S_NSQ;
            end else begin
              gn_r    <= iter_res[31:0];
              state_r <= S_SA;
            end
          end
        end
        S_SA: state_r <= S_SAW;
        S_SAW: begin
          if (iter_done) begin
            asn_r   <= iter_res[24:0];
            state_r <= S_SGW;
          end
        end
        S_SGW: begin
          if (iter_done) begin
            gsn_r   <= iter_res[24:0];
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          priority if (an_r < min_accel_r) begin
            st_r    <= enough ? isid_pkg::ST_REJ_MEAN : isid_pkg::ST_COLLECT;
            rej_r   <= enough;
            gsel_r  <= 1'b0;
            state_r <= S_EMIT;
          end else if (enough && !replay_r && !still) begin
            st_r    <= isid_pkg::ST_REJ_MOVE;
            rej_r   <= 1'b1;
            gsel_r  <= 1'b0;
            state_r <= S_EMIT;
          end else if (enough) begin
            st_r   <= still ? isid_pkg::ST_ACCEPT : isid_pkg::ST_UNSTEADY;
            rej_r  <= 1'b0;
            done_r <= 1'b1;
            gsel_r <= 1'b1;
            if (an_r == 32'd0) begin
              for (int i = 0; i < 3; i++) grav_r[i] <= '0;
              state_r <= S_EMIT;
            end else begin
              j_r     <= '0;
              state_r <= S_GMUL;
            end
          end else begin
            st_r    <= isid_pkg::ST_COLLECT;
            rej_r   <= 1'b0;
            gsel_r  <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_GMUL:  state_r <= S_GMUL2;
        S_GMUL2: state_r <= S_GDIV;
        S_GDIV: begin
          if (iter_done) begin
            grav_r[j_r] <= mean_r[{1'b0, j_r}][31] ? gq : -gq;
            if (j_r == 2'd2) state_r <= S_EMIT;
            else begin
              j_r     <= j_r + 2'd1;
              state_r <= S_GMUL;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= st_r;
            out_data_r  <= {tot_sat,
                            gsel_r ? grav_r[2] : 32'd0,
                            gsel_r ? grav_r[1] : 32'd0,
                            gsel_r ? grav_r[0] : 32'd0,
                            mean_r[5], mean_r[4], mean_r[3],
                            mean_r[2], mean_r[1], mean_r[0]};
            // a rejection restarts the window after the beat is loaded
            if (rej_r) begin
              for (int i = 0; i < 6; i++) begin
                mean_r[i] <= (i == 2) ? -isid_pkg::ONE_Q16 : 32'd0;
                var_r[i]  <= isid_pkg::VAR_INIT_Q16;
              end
              cnt_r     <= COUNT_BITS'(1);
              start_r   <= '0;
              end_r     <= '0;
              started_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

### tb/imu_stationary_init_detector_test.sv
// self-checking bench for imu_stationary_init_detector: directed table, then random windows
// over several register settings, every result checked against an in-bench predictor
// depends on isid_pkg and the detector rtl
`default_nettype none
module imu_stationary_init_detector_test;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 6000;
  localparam logic [63:0] COUNT_TOP = 64'd65535;

  typedef struct {
    int                 acc[3];
    int                 rate[3];
    bit [47:0]          stamp;
    bit                 last;
    bit                 typed;
    isid_pkg::status_t  want;
  } sample_t;

  typedef struct {
    isid_pkg::status_t  st;
    bit [303:0]         data;
    bit                 typed;
    isid_pkg::status_t  want;
  } verdict_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [239:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [303:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  imu_stationary_init_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // predictor state
  bit [31:0]  lim[8];
  int         acc_avg[3];
  int         rot_avg[3];
  bit [31:0]  acc_spread[3];
  bit [31:0]  rot_spread[3];
  bit [63:0]  n_count;
  bit [63:0]  t_first;
  bit [63:0]  t_last;
  bit         armed;
  bit         locked;

  verdict_t   pending_q[$];
  int         errors;
  int         items_sent;
  int         seen[8];
  int unsigned idle_cycles;
  bit         hold_req;
  bit         send_quiet;
  bit         recv_quiet;
  bit [47:0]  clock_us;
  sample_t    table_rows[$];

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] absval(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] vec_norm(int a, int b, int c);
    return isqrt(absval(a) * absval(a) + absval(b) * absval(b) + absval(c) * absval(c));
  endfunction

  function automatic bit [63:0] spread_norm(bit [31:0] a, bit [31:0] b, bit [31:0] c);
    return isqrt((64'(a) + 64'(b) + 64'(c)) << 16);
  endfunction

  function automatic bit [31:0] spread_step(bit [31:0] v, longint e, bit [63:0] n);
    bit [63:0] prev, ae, hi, lo, sq, term, tot;
    prev = 64'(v) * (n - 1) / n;
    ae = absval(e);
    hi = ae >> 16;
    lo = ae & 64'hFFFF;
    sq = ((hi * hi) << 16) + 64'd2 * hi * lo + ((lo * lo) >> 16);
    term = ((sq / n) * (n - 1)) / n;
    tot = prev + term;
    return tot > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : tot[31:0];
  endfunction

  function automatic bit [31:0] down_axis(int m, bit [63:0] nrm);
    bit [63:0] mg;
    if (nrm == 0) return 32'd0;
    mg = absval(m) * 64'(isid_pkg::G_Q16) / nrm;
    return m < 0 ? mg[31:0] : 32'(-mg);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 3; i++) begin
      acc_avg[i] = 0;
      rot_avg[i] = 0;
      acc_spread[i] = isid_pkg::VAR_INIT_Q16;
      rot_spread[i] = isid_pkg::VAR_INIT_Q16;
    end
    acc_avg[2] = -int'(isid_pkg::ONE_Q16);
    n_count = 1;
    t_first = 0;
    t_last = 0;
    armed = 0;
  endfunction

  function automatic void absorb(sample_t s);
    bit [63:0] n;
    longint d;
    if (!armed) begin
      clear_window();
      armed = 1;
      for (int i = 0; i < 3; i++) begin
        acc_avg[i] = s.acc[i];
        rot_avg[i] = s.rate[i];
      end
      t_first = 64'(s.stamp);
    end
    t_last = 64'(s.stamp);
    n = n_count;
    for (int i = 0; i < 3; i++) begin
      d = longint'(s.acc[i]) - longint'(acc_avg[i]);
      acc_avg[i] = int'(longint'(acc_avg[i]) + d / longint'(n));
      acc_spread[i] = spread_step(acc_spread[i], longint'(s.acc[i]) - longint'(acc_avg[i]), n);
      d = longint'(s.rate[i]) - longint'(rot_avg[i]);
      rot_avg[i] = int'(longint'(rot_avg[i]) + d / longint'(n));
      rot_spread[i] = spread_step(rot_spread[i], longint'(s.rate[i]) - longint'(rot_avg[i]), n);
    end
    if (n_count < COUNT_TOP) n_count++;
  endfunction

  // works out the result of one sample and advances the predictor state
  function automatic verdict_t judge_sample(sample_t s);
    verdict_t  v;
    bit        grav, reject, enough, still;
    bit [63:0] samples, span, an, total;
    grav = 0;
    reject = 0;
    v.st = isid_pkg::ST_COLLECT;
    v.typed = s.typed;
    v.want = s.want;
    if (locked) begin
      v.st = isid_pkg::ST_DONE;
      grav = 1;
    end else begin
      absorb(s);
      if (s.last) begin
        samples = n_count - 1;
        span = t_last >= t_first ? t_last - t_first : 64'd0;
        enough = samples >= 64'(lim[isid_pkg::CFG_MIN_TOTAL]) &&
                 span >= 64'(lim[isid_pkg::CFG_MIN_WINDOW]);
        an = vec_norm(acc_avg[0], acc_avg[1], acc_avg[2]);
        if (an < 64'(lim[isid_pkg::CFG_MIN_ACCEL])) begin
          if (enough) begin
            v.st = isid_pkg::ST_REJ_MEAN;
            reject = 1;
          end
        end else begin
          still = an <= 64'(lim[isid_pkg::CFG_MAX_ACCEL]) &&
                  vec_norm(rot_avg[0], rot_avg[1], rot_avg[2]) <=
                    64'(lim[isid_pkg::CFG_MAX_GMEAN]) &&
                  spread_norm(acc_spread[0], acc_spread[1], acc_spread[2]) <=
                    64'(lim[isid_pkg::CFG_MAX_ASTD]) &&
                  spread_norm(rot_spread[0], rot_spread[1], rot_spread[2]) <=
                    64'(lim[isid_pkg::CFG_MAX_GSTD]);
          if (enough && lim[isid_pkg::CFG_REPLAY] == 0 && !still) begin
            v.st = isid_pkg::ST_REJ_MOVE;
            reject = 1;
          end else if (enough) begin
            v.st = still ? isid_pkg::ST_ACCEPT : isid_pkg::ST_UNSTEADY;
            locked = 1;
            grav = 1;
          end
        end
      end
    end
    an = vec_norm(acc_avg[0], acc_avg[1], acc_avg[2]);
    total = n_count - 1;
    v.data = '0;
    for (int i = 0; i < 3; i++) begin
      v.data[32*i +: 32] = acc_avg[i];
      v.data[96 + 32*i +: 32] = rot_avg[i];
      v.data[192 + 32*i +: 32] = grav ? down_axis(acc_avg[i], an) : 32'd0;
    end
    v.data[303:288] = total > 64'hFFFF ? 16'hFFFF : total[15:0];
    if (reject) clear_window();
    return v;
  endfunction

  function automatic sample_t row(int ax, int ay, int az, int rx, int ry, int rz,
                                  bit [47:0] stamp, bit last, bit typed,
                                  isid_pkg::status_t want);
    sample_t s;
    s.acc[0] = ax;
    s.acc[1] = ay;
    s.acc[2] = az;
    s.rate[0] = rx;
    s.rate[1] = ry;
    s.rate[2] = rz;
    s.stamp = stamp;
    s.last = last;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic int draw_gap(ref bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic int jitter(int amp);
    return amp == 0 ? 0 : int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic void flag_error(string msg);
    if (errors < 10) $display("mismatch: %s", msg);
    errors++;
  endfunction

  task automatic offer(sample_t s);
    int g;
    g = draw_gap(send_quiet);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s.stamp, s.rate[2], s.rate[1], s.rate[0], s.acc[2], s.acc[1], s.acc[0]};
    in_tlast <= s.last;
    do @(posedge clk); while (!in_tready);
    pending_q = {pending_q, judge_sample(s)};
    items_sent++;
  endtask

  // drop valid after the last beat and wait for every result
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == isid_pkg::CFG_MIN_TOTAL) lim[idx] = val & 32'hFFFF;
    else if (idx == isid_pkg::CFG_REPLAY) lim[idx] = val & 32'h1;
    else lim[idx] = val;
  endtask

  task automatic set_all(bit [31:0] a0, bit [31:0] a1, bit [31:0] a2, bit [31:0] a3,
                         bit [31:0] a4, bit [31:0] a5, bit [31:0] a6, bit [31:0] a7);
    write_reg(isid_pkg::CFG_MIN_ACCEL, a0);
    write_reg(isid_pkg::CFG_MAX_ACCEL, a1);
    write_reg(isid_pkg::CFG_MAX_GMEAN, a2);
    write_reg(isid_pkg::CFG_MAX_ASTD, a3);
    write_reg(isid_pkg::CFG_MAX_GSTD, a4);
    write_reg(isid_pkg::CFG_MIN_TOTAL, a5);
    write_reg(isid_pkg::CFG_MIN_WINDOW, a6);
    write_reg(isid_pkg::CFG_REPLAY, a7);
    cfg_we <= 1'b0;
  endtask

  // windows of samples around a random mean, closed by a frame end, with noise beats mixed in
  task automatic random_windows(int count, int rate_lo, int rate_hi, bit zero_ok, int hold_at);
    sample_t s;
    int      sent, len, amp, ramp;
    int      acc_base[3];
    int      rate_base[3];
    sent = 0;
    while (sent < count) begin
      for (int i = 0; i < 3; i++) begin
        acc_base[i] = (zero_ok && $urandom_range(0, 2) == 0) ? 0
                      : int'($urandom_range(0, 140000)) - 70000;
        rate_base[i] = int'($urandom_range(rate_lo, rate_hi));
        if ($urandom_range(0, 1)) rate_base[i] = -rate_base[i];
      end
      case ($urandom_range(0, 3))
        0: amp = 0;
        1: amp = 64;
        2: amp = 2048;
        default: amp = 40000;
      endcase
      ramp = $urandom_range(0, 1) ? 16 : 500;
      len = int'($urandom_range(1, 24));
      for (int k = 0; k < len && sent < count; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          for (int i = 0; i < 3; i++) begin
            s.acc[i] = int'($urandom);
            s.rate[i] = int'($urandom);
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            s.acc[i] = acc_base[i] + jitter(amp);
            s.rate[i] = rate_base[i] + jitter(ramp);
          end
        end
        if ($urandom_range(0, 39) == 0) clock_us = 48'({$urandom, $urandom});
        else clock_us = clock_us + 48'($urandom_range(0, 300000));
        s.stamp = clock_us;
        s.last = (k == len - 1) || ($urandom_range(0, 9) == 0);
        s.typed = 0;
        s.want = isid_pkg::ST_COLLECT;
        offer(s);
        sent++;
        if (sent == hold_at) hold_req = 1;
      end
    end
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_tvalid && out_tready) begin
      seen[out_tuser]++;
      if (pending_q.size() == 0) begin
        flag_error($sformatf("result with nothing pending, status %0d", out_tuser));
      end else begin
        v = pending_q.pop_front();
        if (out_tuser != v.st)
          flag_error($sformatf("status exp %0d got %0d", v.st, out_tuser));
        if (v.typed && out_tuser != v.want)
          flag_error($sformatf("table status exp %0d got %0d", v.want, out_tuser));
        for (int i = 0; i < 9; i++)
          if (out_tdata[32*i +: 32] != v.data[32*i +: 32])
            flag_error($sformatf("word %0d exp %h got %h", i, v.data[32*i +: 32],
                                 out_tdata[32*i +: 32]));
        if (out_tdata[303:288] != v.data[303:288])
          flag_error($sformatf("sample_total exp %0d got %0d", v.data[303:288],
                               out_tdata[303:288]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = draw_gap(recv_quiet);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    hold_req = 0;
    send_quiet = 0;
    recv_quiet = 0;
    clock_us = 48'd5000;
    locked = 0;
    lim[isid_pkg::CFG_MIN_ACCEL] = 32768;
    lim[isid_pkg::CFG_MAX_ACCEL] = 98304;
    lim[isid_pkg::CFG_MAX_GMEAN] = 3277;
    lim[isid_pkg::CFG_MAX_ASTD] = 3277;
    lim[isid_pkg::CFG_MAX_GSTD] = 1311;
    lim[isid_pkg::CFG_MIN_TOTAL] = 100;
    lim[isid_pkg::CFG_MIN_WINDOW] = 1000000;
    lim[isid_pkg::CFG_REPLAY] = 0;
    clear_window();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;

    table_rows = {table_rows, row(0, 0, 65536, 0, 0, 0, 48'd100, 0, 1, isid_pkg::ST_COLLECT)};
    // huge positive mean with enough samples: moving
    table_rows = {table_rows, row(int'(32'h7FFF_FFFF), int'(32'h7FFF_FFFF),
                                  int'(32'h7FFF_FFFF), 0, 0, 0, 48'd200, 1, 1,
                                  isid_pkg::ST_REJ_MOVE)};
    // zero mean, one sample: not enough yet, no reset
    table_rows = {table_rows, row(0, 0, 0, 0, 0, 0, 48'd300, 1, 1, isid_pkg::ST_COLLECT)};
    table_rows = {table_rows, row(0, 0, 0, 0, 0, 0, 48'd400, 1, 1, isid_pkg::ST_REJ_MEAN)};
    table_rows = {table_rows, row(int'(32'h8000_0000), int'(32'h8000_0000),
                                  int'(32'h8000_0000), int'(32'h8000_0000),
                                  int'(32'h8000_0000), int'(32'h8000_0000),
                                  48'hFFFF_FFFF_FFFF, 0, 1, isid_pkg::ST_COLLECT)};
    // stamp goes backward: span counts as zero
    table_rows = {table_rows, row(int'(32'h8000_0000), int'(32'h8000_0000),
                                  int'(32'h8000_0000), int'(32'h7FFF_FFFF),
                                  int'(32'h7FFF_FFFF), int'(32'h7FFF_FFFF),
                                  48'd0, 1, 1, isid_pkg::ST_REJ_MOVE)};
    table_rows = {table_rows, row(0, 0, 65536, 0, 0, 0, 48'd1000, 0, 1,
                                  isid_pkg::ST_COLLECT)};
    table_rows = {table_rows, row(0, 0, 65536, int'(32'h7FFF_FFFF), 0, 0, 48'd2000, 1, 0,
                                  isid_pkg::ST_COLLECT)};
    table_rows = {table_rows, row(-65536, 300, 12, -5, 7, 9, 48'h8000_0000_0000, 0, 0,
                                  isid_pkg::ST_COLLECT)};
    table_rows = {table_rows, row(65536, -300, -12, 5, -7, -9, 48'h8000_0000_1000, 1, 0,
                                  isid_pkg::ST_COLLECT)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_all(32768, 98304, 3277, 3277, 1311, 2, 0, 0);
    foreach (table_rows[i]) offer(table_rows[i]);
    settle();

    set_all(32768, 98304, 3277, 3277, 1311, 8, 200000, 0);
    random_windows(880, 4000, 20000, 0, 300);
    settle();

    // extremes: every frame end rejects on the mean
    set_all(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    random_windows(250, 0, 100000, 1, -1);
    settle();

    // extremes: never enough data, statistics keep growing
    set_all(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF,
            32'hFFFF_FFFF, 0);
    random_windows(110, 0, 100000, 0, -1);
    settle();

    // replay: first window with enough samples is taken, then done beats
    set_all(0, 98304, 3277, 3277, 1311, 20, 0, 1);
    random_windows(150, 0, 200, 1, -1);
    settle();

    repeat (2100) @(posedge clk);
    $display("%0d samples sent; results: %0d collecting, %0d accepted, %0d unsteady,",
             items_sent, seen[isid_pkg::ST_COLLECT], seen[isid_pkg::ST_ACCEPT],
             seen[isid_pkg::ST_UNSTEADY]);
    $display("  %0d moving rejects, %0d bad-mean rejects, %0d done; %0d mismatches",
             seen[isid_pkg::ST_REJ_MOVE], seen[isid_pkg::ST_REJ_MEAN],
             seen[isid_pkg::ST_DONE], errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
hw/rtl/isid_pkg.sv
hw/rtl/isid_iter.sv
hw/rtl/imu_stationary_init_detector.sv
tb/imu_stationary_init_detector_test.sv
